// File: hw/rtl/reservoir_sampler_core_assert.svh
// assertion macros shared by the reservoir sampler rtl
// no dependencies; included by the modules that check their own logic
`ifndef RESERVOIR_SAMPLER_CORE_ASSERT_SVH
`define RESERVOIR_SAMPLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RS_ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("reservoir sampler check failed");
`define RS_ASSERT_IMPLIES(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("reservoir sampler check failed");
`define RS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("reservoir sampler check failed");
`else
`define RS_ASSERT_HOLDS(lbl, clk, rstn, prop)
`define RS_ASSERT_IMPLIES(lbl, clk, rstn, pre, post)
`define RS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// File: hw/rtl/rs_pkg.sv
// types and constants of the reservoir sampler
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps
package rs_pkg;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int K_W         = 7;
    localparam int VALUE_W     = 32;
    localparam int RAND_W      = 32;
    localparam int SEEN_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [0:0] {
        CMD_PUSH  = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_FLUSH = 1'b1
    } op_kind_t;

    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_OUT  = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_t                       command;
        logic signed [VALUE_W-1:0]  value;
        logic [RAND_W-1:0]          random_word;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  sample_value;
        logic [IDX_W-1:0]           slot_index;
        logic                       last;
    } out_item_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic [IDX_W-1:0]           addr;
        logic [K_W-1:0]             count;
        logic [VALUE_W-1:0]         value;
    } op_t;

endpackage

// File: hw/rtl/reservoir_sampler_core.sv
// top level of the reservoir sampler: config register, front end, queue, back end
// depends on rs_pkg, rs_front, rs_queue, rs_back
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_valid/cfg_ready  cfg_data, sample size k
//   s         in         s_valid/s_ready      rs_pkg::in_item_t
//   m         out        m_valid/m_ready      rs_pkg::out_item_t
//
// a push is registered in the front stage, which also holds the slot multiply, and the
// back end writes it to memory; pushes stream at one per cycle while the queue has room.
// a flush first reads slot 0, then gives one result per cycle while m_ready is high from
// the single port reservoir memory: min(seen, k) results from the back end.
// reset is synchronous and clears the seen count, queue and sequencer; no memory sweep.
// a stalled m channel holds the back end; the queue lets the front take a few more pushes.
`timescale 1ns / 1ps
module reservoir_sampler_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rs_pkg::K_W-1:0]   cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rs_pkg::in_item_t         s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rs_pkg::out_item_t        m_item
);

    logic [rs_pkg::K_W-1:0] sample_size_reg, sample_size_next;
    logic [rs_pkg::K_W-1:0] k_eff;
    logic                   fq_valid, fq_ready;
    rs_pkg::op_t            fq_op;
    logic                   qb_valid, qb_ready;
    rs_pkg::op_t            qb_op;

    assign cfg_ready        = 1'b1;
    assign sample_size_next = (cfg_valid && cfg_ready) ? cfg_data : sample_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_size_reg <= rs_pkg::K_W'(1);
        end else begin
            sample_size_reg <= sample_size_next;
        end
    end

    // zero acts as one, above depth clamps to depth
    always_comb begin
        k_eff = sample_size_reg;
        if (sample_size_reg == '0) begin
            k_eff = rs_pkg::K_W'(1);
        end else if (sample_size_reg > rs_pkg::K_W'(rs_pkg::DEPTH)) begin
            k_eff = rs_pkg::K_W'(rs_pkg::DEPTH);
        end
    end

    rs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .k_eff   (k_eff),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_op    (fq_op)
    );

    rs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_op    (fq_op),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_op     (qb_op)
    );

    rs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_op    (qb_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// File: hw/rtl/rs_front.sv
// front end: accepts transactions, keeps the seen count, picks the slot
// depends on rs_pkg; feeds rs_queue
`timescale 1ns / 1ps
module rs_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [rs_pkg::K_W-1:0] k_eff,
    input  logic               s_valid,
    output logic               s_ready,
    input  rs_pkg::in_item_t   s_item,
    output logic               q_valid,
    input  logic               q_ready,
    output rs_pkg::op_t        q_op
);

    logic [rs_pkg::SEEN_W-1:0]   seen_reg, seen_next;
    logic                        st_valid_reg, st_valid_next;
    logic                        st_rand_reg;
    rs_pkg::op_t                 st_op_reg;
    logic [rs_pkg::RAND_W-1:0]   st_rnd_reg;
    logic [rs_pkg::SEEN_W:0]     st_span_reg;

    logic                        accept;
    logic                        fill;
    logic [rs_pkg::K_W-1:0]      count;
    logic [rs_pkg::RAND_W+rs_pkg::SEEN_W:0] prod;
    logic [rs_pkg::SEEN_W:0]     slot_hi;
    logic                        hit;
    logic                        emit;

    assign accept = s_valid && s_ready;
    assign fill   = seen_reg < rs_pkg::SEEN_W'(k_eff);
    assign count  = fill ? seen_reg[rs_pkg::K_W-1:0] : k_eff;

    // slot choice: high part of random word times (seen + 1)
    assign prod    = {{(rs_pkg::SEEN_W+1){1'b0}}, st_rnd_reg}
                   * {{rs_pkg::RAND_W{1'b0}}, st_span_reg};
    assign slot_hi = prod[rs_pkg::RAND_W+rs_pkg::SEEN_W:rs_pkg::RAND_W];
    assign hit     = slot_hi < (rs_pkg::SEEN_W+1)'(k_eff);

    always_comb begin
        emit = st_valid_reg;
        if (st_op_reg.kind == rs_pkg::OP_FLUSH && st_op_reg.count == '0) begin
            emit = 1'b0;
        end
        if (st_op_reg.kind == rs_pkg::OP_WRITE && st_rand_reg && !hit) begin
            emit = 1'b0;
        end
    end

    always_comb begin
        q_op = st_op_reg;
        if (st_rand_reg) begin
            q_op.addr = slot_hi[rs_pkg::IDX_W-1:0];
        end
    end

    assign q_valid = emit;
    assign s_ready = !st_valid_reg || !emit || q_ready;

    always_comb begin
        seen_next     = seen_reg;
        st_valid_next = st_valid_reg;
        if (s_ready) begin
            st_valid_next = s_valid;
        end
        if (accept) begin
            unique case (s_item.command)
                rs_pkg::CMD_PUSH: begin
                    if (seen_reg != '1) begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
                rs_pkg::CMD_FLUSH: seen_next = '0;
                default:           seen_next = seen_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            seen_reg     <= seen_next;
            st_valid_reg <= st_valid_next;
        end
    end

    // payload of the slot stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_op_reg.kind  <= (s_item.command == rs_pkg::CMD_FLUSH) ?
                               rs_pkg::OP_FLUSH : rs_pkg::OP_WRITE;
            st_op_reg.addr  <= seen_reg[rs_pkg::IDX_W-1:0];
            st_op_reg.count <= count;
            st_op_reg.value <= s_item.value;
            st_rand_reg     <= !fill;
            st_rnd_reg      <= s_item.random_word;
            st_span_reg     <= {1'b0, seen_reg} + 1'b1;
        end
    end

endmodule

// File: hw/rtl/rs_queue.sv
// short fifo of operations between front end and back end
// depends on rs_pkg and reservoir_sampler_core_assert.svh
`timescale 1ns / 1ps
`include "reservoir_sampler_core_assert.svh"
module rs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  rs_pkg::op_t   push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rs_pkg::op_t   pop_op
);

    rs_pkg::op_t                 entry_reg [rs_pkg::QUEUE_DEPTH];
    logic [rs_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rs_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rs_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    assign push_ready = cnt_reg != rs_pkg::QCNT_W'(rs_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `RS_ASSERT_HOLDS(a_cnt_bound, aclk, aresetn, cnt_reg <= rs_pkg::QCNT_W'(rs_pkg::QUEUE_DEPTH))

endmodule

// File: hw/rtl/rs_back.sv
// back end: reservoir memory, slot writes and the flush walk
// depends on rs_pkg and reservoir_sampler_core_assert.svh; drains rs_queue
`timescale 1ns / 1ps
`include "reservoir_sampler_core_assert.svh"
module rs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  rs_pkg::op_t       q_op,
    output logic              m_valid,
    input  logic              m_ready,
    output rs_pkg::out_item_t m_item
);

    logic [rs_pkg::VALUE_W-1:0] mem [rs_pkg::DEPTH];
    logic [rs_pkg::VALUE_W-1:0] rd_data_reg;

    rs_pkg::back_state_t        state_reg, state_next;
    logic [rs_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [rs_pkg::K_W-1:0]     cnt_reg, cnt_next;

    logic                       mem_we, mem_re;
    logic [rs_pkg::IDX_W-1:0]   rd_addr;
    logic                       is_last;

    assign is_last = (rs_pkg::K_W'(out_idx_reg) + 1'b1) == cnt_reg;

    always_comb begin
        state_next   = state_reg;
        out_idx_next = out_idx_reg;
        cnt_next     = cnt_reg;
        q_ready      = 1'b0;
        m_valid      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        rd_addr      = '0;
        unique case (state_reg)
            rs_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    unique case (q_op.kind)
                        rs_pkg::OP_WRITE: mem_we = 1'b1;
                        rs_pkg::OP_FLUSH: begin
                            mem_re       = 1'b1;
                            out_idx_next = '0;
                            cnt_next     = q_op.count;
                            state_next   = rs_pkg::BK_OUT;
                        end
                        default: mem_we = 1'b0;
                    endcase
                end
            end
            rs_pkg::BK_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (is_last) begin
                        state_next = rs_pkg::BK_IDLE;
                    end else begin
                        mem_re       = 1'b1;
                        rd_addr      = out_idx_reg + 1'b1;
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = rs_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rs_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_idx_reg <= out_idx_next;
        cnt_reg     <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_op.addr] <= q_op.value;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_item.sample_value = rd_data_reg;
    assign m_item.slot_index   = out_idx_reg;
    assign m_item.last         = is_last;

    `RS_ASSERT_IMPLIES(a_idx_in_range, aclk, aresetn, state_reg == rs_pkg::BK_OUT, rs_pkg::K_W'(out_idx_reg) < cnt_reg)
    `RS_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_item.last, !m_valid)
    `RS_ASSERT_IMPLIES(a_no_pop_busy, aclk, aresetn, state_reg == rs_pkg::BK_OUT, !q_ready && !mem_we)

endmodule

// File: tb/reservoir_sampler_checker.sv
// checker for reservoir_sampler_core: watches the cfg, s and m channels, predicts every
// flush result from its own reservoir copy and compares each m transaction in order
// depends on rs_pkg
`timescale 1ns / 1ps
module reservoir_sampler_checker
    import rs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [K_W-1:0]   cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_item_t         s_item,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_item_t        m_item,
    output int               mismatches,
    output int               pending,
    output int               results_checked
);

    logic [VALUE_W-1:0] sample_mem [DEPTH];
    logic [SEEN_W-1:0]  seen_total;
    logic [K_W-1:0]     size_reg;
    out_item_t          sample_q [$];
    out_item_t          want;
    logic [63:0]        span_prod;
    int unsigned        k_use;
    int unsigned        emit_cnt;
    logic               bad;

    function automatic int unsigned active_size(logic [K_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > DEPTH) return DEPTH;
        return raw;
    endfunction

    initial begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
        seen_total      = '0;
        size_reg        = K_W'(1);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            seen_total = '0;
            size_reg   = K_W'(1);
            sample_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                k_use = active_size(size_reg);
                if (s_item.command == CMD_PUSH) begin
                    if (seen_total < k_use) begin
                        sample_mem[seen_total[IDX_W-1:0]] = s_item.value;
                    end else begin
                        // slot = (random_word * (seen + 1)) >> 32, kept only below k
                        span_prod = {32'd0, s_item.random_word} * ({32'd0, seen_total} + 64'd1);
                        if (span_prod[63:32] < k_use) begin
                            sample_mem[span_prod[IDX_W+31:32]] = s_item.value;
                        end
                    end
                    if (seen_total != '1) seen_total = seen_total + 1'b1;
                end else begin
                    emit_cnt = (seen_total < k_use) ? seen_total : k_use;
                    for (int i = 0; i < emit_cnt; i++) begin
                        want.sample_value = sample_mem[i];
                        want.slot_index   = IDX_W'(i);
                        want.last         = (i + 1 == emit_cnt);
                        sample_q.push_back(want);
                    end
                    seen_total = '0;
                end
            end
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transaction: value %h slot %0d last %b",
                                 m_item.sample_value, m_item.slot_index, m_item.last);
                    end
                end else begin
                    want = sample_q.pop_front();
                    bad  = (m_item.sample_value !== want.sample_value) ||
                           (m_item.slot_index !== want.slot_index) ||
                           (m_item.last !== want.last);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at result %0d: expected value %h slot %0d last %b, got value %h slot %0d last %b",
                                     results_checked, want.sample_value, want.slot_index,
                                     want.last, m_item.sample_value, m_item.slot_index,
                                     m_item.last);
                        end
                    end
                    results_checked++;
                end
            end
        end
        pending = sample_q.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for reservoir_sampler_core: clock, reset, stimulus and verdict
// depends on rs_pkg, reservoir_sampler_core and reservoir_sampler_checker
`timescale 1ns / 1ps
module tb_top;
    import rs_pkg::*;

    localparam int      ITEM_TARGET   = 270;
    localparam int      SETTLE_CYCLES = 32;
    localparam int      LONG_HOLD     = 400;
    localparam longint  LIMIT_NS      = 64'd4_000_000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [K_W-1:0]    cfg_data;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_item;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_item;

    int                mism;
    int                pend;
    int                checked;

    // stimulus side bookkeeping, only to keep reads inside written slots
    int                seen_cnt   = 0;
    int                filled     = 0;
    int                k_now      = 1;
    int                items_sent = 0;
    int                cfg_writes = 0;
    bit                steady     = 1'b0;
    bit                hold_m     = 1'b0;

    always #2 aclk = ~aclk;

    reservoir_sampler_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    reservoir_sampler_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .mismatches      (mism),
        .pending         (pend),
        .results_checked (checked)
    );

    function automatic int size_of(logic [K_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > DEPTH) return DEPTH;
        return raw;
    endfunction

    // clamp a mid-stream size so a flush never reaches a slot never written
    function automatic logic [K_W-1:0] safe_size(logic [K_W-1:0] raw);
        int m;
        m = size_of(raw);
        if (seen_cnt < m) m = seen_cnt;
        if (m > filled) return K_W'(filled);
        return raw;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(cmd_t cmd, logic [31:0] val, logic [31:0] rnd);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= '{command: cmd, value: val, random_word: rnd};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_PUSH) begin
            if (seen_cnt < k_now && seen_cnt + 1 > filled) filled = seen_cnt + 1;
            seen_cnt++;
        end else begin
            seen_cnt = 0;
        end
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pend != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(logic [K_W-1:0] raw);
        settle();
        cfg_data  <= raw;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        k_now = size_of(raw);
        cfg_writes++;
    endtask

    task automatic run_stream(int pushes, bit resize);
        for (int i = 0; i < pushes; i++) begin
            if (resize && i == pushes / 2) write_size(safe_size(K_W'($urandom_range(0, 127))));
            if ($urandom_range(0, 9) == 0) begin
                send_item(cmd_t'($urandom_range(0, 1)), $urandom, $urandom);
            end else begin
                send_item(CMD_PUSH, pick_word(), pick_word());
            end
        end
        send_item(CMD_FLUSH, $urandom, $urandom);
    endtask

    // result side: random back-pressure plus one long hold on request
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 16);
            if (hold_m) begin
                gap    = LONG_HOLD;
                hold_m = 1'b0;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int               phase;
        int               lim;
        logic [K_W-1:0]   sz;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // flush with nothing seen
        send_item(CMD_FLUSH, 32'h0, 32'h0);
        // size zero acts as one
        write_size(K_W'(0));
        send_item(CMD_PUSH, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_PUSH, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(CMD_PUSH, 32'hffff_ffff, 32'h0000_0000);
        send_item(CMD_FLUSH, 32'hffff_ffff, 32'hffff_ffff);
        // fill then replace, extreme random words
        write_size(K_W'(3));
        send_item(CMD_PUSH, 32'h0000_0000, 32'hffff_ffff);
        send_item(CMD_PUSH, 32'h0000_0001, 32'h0000_0000);
        send_item(CMD_PUSH, 32'hffff_ffff, 32'h8000_0000);
        send_item(CMD_PUSH, 32'h7fff_ffff, 32'h0000_0000);
        send_item(CMD_PUSH, 32'h8000_0000, 32'hffff_ffff);
        send_item(CMD_FLUSH, 32'h0, 32'h0);
        // size above depth saturates
        write_size(K_W'(127));
        send_item(CMD_PUSH, 32'h1234_5678, 32'h0000_0000);
        send_item(CMD_PUSH, 32'hfedc_ba98, 32'hffff_ffff);
        send_item(CMD_PUSH, 32'h8000_0001, 32'h5555_aaaa);
        send_item(CMD_FLUSH, 32'h0, 32'h0);
        // size lowered mid-stream
        write_size(K_W'(4));
        repeat (6) send_item(CMD_PUSH, pick_word(), pick_word());
        write_size(safe_size(K_W'(2)));
        repeat (2) send_item(CMD_PUSH, pick_word(), pick_word());
        send_item(CMD_FLUSH, 32'h0, 32'h0);

        // full depth with replacement while the result side holds off
        write_size(K_W'(64));
        steady = 1'b1;
        hold_m = 1'b1;
        repeat (72) send_item(CMD_PUSH, pick_word(), pick_word());
        send_item(CMD_FLUSH, $urandom, $urandom);
        repeat (8) send_item(CMD_PUSH, pick_word(), pick_word());
        send_item(CMD_FLUSH, $urandom, $urandom);
        steady = 1'b0;

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            steady = (phase % 3 == 1);
            case (phase)
                0:       sz = K_W'(64);
                1:       sz = K_W'(1);
                2:       sz = K_W'(127);
                3:       sz = K_W'(0);
                default: sz = ($urandom_range(0, 3) == 0) ? K_W'($urandom_range(0, 127))
                                                         : K_W'($urandom_range(1, 8));
            endcase
            write_size(safe_size(sz));
            repeat ($urandom_range(1, 3)) begin
                if (items_sent < ITEM_TARGET) begin
                    lim = k_now * 2 + 3;
                    if (lim > 40) lim = 40;
                    run_stream($urandom_range(0, lim), $urandom_range(0, 3) == 0);
                end
            end
            phase++;
        end

        settle();
        repeat (DEPTH) @(posedge aclk);
        $display("covered %0d input transactions over %0d sample size writes,",
                 items_sent, cfg_writes);
        $display("empty, resized and full-depth flushes; %0d results compared, %0d mismatches",
                 checked, mism);
        if (mism == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rs_pkg.sv
hw/rtl/rs_front.sv
hw/rtl/rs_queue.sv
hw/rtl/rs_back.sv
hw/rtl/reservoir_sampler_core.sv
tb/reservoir_sampler_checker.sv
tb/tb_top.sv
